>>> hw/rtl/sha1_stream_hasher_unit_assert.svh
// Assertion macros used by the SHA-1 hasher controller.
`ifndef SHA1_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA1_STREAM_HASHER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define SHU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
// Checked at every edge, reset included.
`define SHU_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");
`else
`define SHU_ASSERT(lbl, prop)
`define SHU_ASSERT_ANY(lbl, prop)
`endif
`endif

>>> hw/rtl/sha1sh_pkg.sv
// Types, constants and round helpers shared by the SHA-1 hasher modules.
package sha1sh_pkg;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_PAD_END = 6'd55;
    localparam logic [6:0] ROUND_LAST   = 7'd79;
    localparam logic [2:0] OUT_LAST     = 3'd4;

    localparam word_t INIT_H [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef enum logic [1:0] {
        BSEL_MSG,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_byte;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      load_work;
        logic      round_step;
        logic      chain_add;
        logic      out_shift;
        logic      restart;
    } hash_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } hash_sts_t;

    function automatic word_t round_k(input logic [6:0] rnd);
        word_t k;
        priority if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        priority if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

>>> hw/rtl/sha1sh_datapath.sv
// SHA-1 datapath: block window, message schedule, round unit, chain and length.
module sha1sh_datapath import sha1sh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  hash_cmd_t  cmd,
    input  logic [7:0] in_byte,
    output hash_sts_t  sts,
    output word_t      digest_word
);

    word_t        chain_reg [5];
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [6:0]   rnd_reg;
    logic [511:0] blk_reg;
    word_t        a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [63:0]  len_shift;
    logic [7:0]   new_byte;
    word_t        w0, sched, new_w, t_sum;

    always_comb begin
        // Length bytes go out most significant first while fill runs 56..63.
        len_shift = bits_reg >> {~fill_reg[2:0], 3'b000};
        unique case (cmd.byte_sel)
            BSEL_MSG:  new_byte = in_byte;
            BSEL_MARK: new_byte = PAD_MARK;
            BSEL_ZERO: new_byte = 8'h00;
            BSEL_LEN:  new_byte = len_shift[7:0];
            default:   new_byte = 8'h00;
        endcase
        // The window top word is w[r]; taps sit 2, 8 and 13 words below it.
        w0    = blk_reg[511 -: 32];
        sched = blk_reg[511 - 32*13 -: 32] ^ blk_reg[511 - 32*8 -: 32]
              ^ blk_reg[511 - 32*2 -: 32] ^ w0;
        new_w = {sched[30:0], sched[31]};
        t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
              + e_reg + w0 + round_k(rnd_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 5; k++) begin
                chain_reg[k] <= INIT_H[k];
            end
            fill_reg <= '0;
            bits_reg <= '0;
            rnd_reg  <= '0;
        end else begin
            if (cmd.shift_byte) begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.restart) begin
                bits_reg <= '0;
            end else if (cmd.count_bits) begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.load_work) begin
                rnd_reg <= '0;
            end else if (cmd.round_step) begin
                rnd_reg <= rnd_reg + 7'd1;
            end
            if (cmd.restart) begin
                for (int k = 0; k < 5; k++) begin
                    chain_reg[k] <= INIT_H[k];
                end
            end else if (cmd.chain_add) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end else if (cmd.out_shift) begin
                for (int k = 0; k < 4; k++) begin
                    chain_reg[k] <= chain_reg[k + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_byte) begin
            blk_reg <= {blk_reg[503:0], new_byte};
        end else if (cmd.round_step) begin
            blk_reg <= {blk_reg[479:0], new_w};
        end
        if (cmd.load_work) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (cmd.round_step) begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign sts.fill       = fill_reg;
    assign sts.round_last = (rnd_reg == ROUND_LAST);
    assign digest_word    = chain_reg[0];

endmodule

>>> hw/rtl/sha1sh_ctrl.sv
// SHA-1 controller: byte intake, padding sequence, compression and digest output.
`include "sha1_stream_hasher_unit_assert.svh"
module sha1sh_ctrl import sha1sh_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      byte_valid,
    input  logic      end_msg,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic      m_tlast,
    input  hash_sts_t sts,
    output hash_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_ADD   = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       mark_reg, mark_next;
    logic       final_reg, final_next;
    logic [2:0] out_cnt_reg, out_cnt_next;

    always_comb begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        mark_next    = mark_reg;
        final_next   = final_reg;
        out_cnt_next = out_cnt_reg;
        cmd          = '0;
        cmd.byte_sel = BSEL_MSG;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tlast      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.shift_byte = byte_valid;
                    cmd.count_bits = byte_valid;
                    if (byte_valid && sts.fill == FILL_LAST) begin
                        cmd.load_work = 1'b1;
                        pend_next     = end_msg;
                        mark_next     = 1'b0;
                        state_next    = ST_ROUND;
                    end else if (end_msg) begin
                        pend_next  = 1'b1;
                        mark_next  = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                priority if (final_reg) begin
                    out_cnt_next = '0;
                    state_next   = ST_OUT;
                end else if (pend_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                // The first padding byte is the end mark; zeros follow.
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = mark_reg ? BSEL_ZERO : BSEL_MARK;
                mark_next      = 1'b1;
                priority if (sts.fill == FILL_LAST) begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_ROUND;
                end else if (sts.fill == FILL_PAD_END) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_LEN: begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_LEN;
                if (sts.fill == FILL_LAST) begin
                    cmd.load_work = 1'b1;
                    final_next    = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                m_tlast  = (out_cnt_reg == OUT_LAST);
                if (m_tready) begin
                    cmd.out_shift = 1'b1;
                    out_cnt_next  = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == OUT_LAST) begin
                        cmd.restart = 1'b1;
                        pend_next   = 1'b0;
                        mark_next   = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            mark_reg    <= 1'b0;
            final_reg   <= 1'b0;
            out_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            mark_reg    <= mark_next;
            final_reg   <= final_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    `SHU_ASSERT_ANY(a_reset_idle, !aresetn |=> state_reg == ST_IDLE)
    `SHU_ASSERT(a_sides_apart, !(s_tready && m_tvalid))
    `SHU_ASSERT(a_round_to_add, (state_reg == ST_ROUND && sts.round_last) |=> state_reg == ST_ADD)
    `SHU_ASSERT(a_len_window, state_reg == ST_LEN |-> sts.fill[5:3] == 3'b111)
    `SHU_ASSERT(a_last_word_restart, (m_tvalid && m_tready && m_tlast) |=> (state_reg == ST_IDLE && sts.fill == 6'd0))

endmodule

>>> hw/rtl/sha1_stream_hasher_unit.sv
// SHA-1 stream hasher: one request per cycle at most, digest after end of message.
// A byte request is taken in the idle state; each full 64-byte block then runs 80 rounds
// on the single round unit plus one chaining add, and no request is taken meanwhile.
// End of message: padding to byte 56 (with a second block and its compression when the
// length does not fit behind the end mark), then 8 length bytes and the compression.
// Bytes are taken one per cycle only in the idle state; the digest goes out as 5 words.
// Reset: synchronous aresetn loads the initial chain value and clears length and fill.
module sha1_stream_hasher_unit import sha1sh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast
);

    hash_cmd_t cmd;
    hash_sts_t sts;

    sha1sh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .byte_valid (s_tuser),
        .end_msg    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .sts        (sts),
        .cmd        (cmd)
    );

    sha1sh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_byte     (s_tdata),
        .sts         (sts),
        .digest_word (m_tdata)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the SHA-1 stream hasher with a built-in digest predictor.
module tb_top;
    import sha1sh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 600;
    localparam int HOLD_AFTER    = 20;
    localparam int DRAIN_CYCLES  = 300;
    localparam int ITEM_TARGET   = 180;
    localparam int MIN_MESSAGES  = 10;
    localparam int GAP_PERCENT   = 6;

    typedef struct {
        word_t word;
        bit    last;
    } digest_entry_t;

    // Predicts the digest words of every message and checks the words that come out.
    class sha1_digest_board;
        localparam bit [31:0] ROUND_CONST [4] = '{
            32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
        };
        localparam bit [31:0] START_CHAIN [5] = '{
            32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
        };
        localparam bit [7:0] PAD_BYTE = 8'h80;

        bit [31:0]     chain [5];
        bit [7:0]      block [64];
        int            fill;
        bit [63:0]     bit_count;
        digest_entry_t pending_words [$];
        int            mismatches;
        int            words_checked;

        function new();
            restart();
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void restart();
            for (int i = 0; i < 5; i++) chain[i] = START_CHAIN[i];
            fill      = 0;
            bit_count = '0;
        endfunction

        function void compress();
            bit [31:0] w [80];
            bit [31:0] a, b, c, d, e, f, t;
            for (int r = 0; r < 16; r++)
                w[r] = {block[4*r], block[4*r+1], block[4*r+2], block[4*r+3]};
            for (int r = 16; r < 80; r++) begin
                t    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
                w[r] = {t[30:0], t[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 20)
                    f = (b & c) | (~b & d);
                else if (r < 40 || r >= 60)
                    f = b ^ c ^ d;
                else
                    f = (b & c) | (b & d) | (c & d);
                t = {a[26:0], a[31:27]} + f + e + w[r] + ROUND_CONST[r / 20];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        // Called for every accepted request.
        function void note_request(bit [7:0] data, bit has_byte, bit ends);
            digest_entry_t entry;
            if (has_byte) begin
                block[fill] = data;
                fill        = (fill + 1) % 64;
                bit_count  += 64'd8;
                if (fill == 0) compress();
            end
            if (!ends) return;
            block[fill] = PAD_BYTE;
            fill++;
            // The length field does not fit behind the pad byte, so one more block goes out.
            if (fill > 56) begin
                while (fill < 64) block[fill++] = 8'h00;
                compress();
                fill = 0;
            end
            while (fill < 56) block[fill++] = 8'h00;
            for (int k = 0; k < 8; k++) block[56 + k] = bit_count[63 - 8*k -: 8];
            compress();
            for (int k = 0; k < 5; k++) begin
                entry.word = chain[k];
                entry.last = (k == 4);
                pending_words.push_back(entry);
            end
            restart();
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 20) $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_word(bit [31:0] word, bit last);
            digest_entry_t entry;
            if (pending_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected digest word %08h", word));
                return;
            end
            entry = pending_words.pop_front();
            words_checked++;
            if (word !== entry.word)
                flag_mismatch($sformatf("digest word %08h, expected %08h", word, entry.word));
            if (last !== entry.last)
                flag_mismatch($sformatf("last flag %0b, expected %0b", last, entry.last));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sha1_digest_board digest_board = new();

    bit gaps_on = 1'b1;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int requests_sent = 0;
    int messages_sent = 0;

    sha1_stream_hasher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: checks each accepted word and drives the ready, with one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                digest_board.check_word(m_tdata, m_tlast);
                if (digest_board.words_checked == HOLD_AFTER && !hold_done) begin
                    hold_left <= HOLD_CYCLES;
                    hold_done <= 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
            end
        end
    end

    task send_request(bit [7:0] data, bit has_byte, bit ends);
        if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= ends;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        digest_board.note_request(data, has_byte, ends);
        requests_sent++;
        if (ends) messages_sent++;
    endtask

    // A message of random bytes, ended either on its last byte or by a request without a byte.
    task send_message(int length, bit end_on_byte, int noise_percent);
        for (int i = 0; i < length; i++) begin
            if ($urandom_range(99) < noise_percent)
                send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(255)), 1'b1, end_on_byte && (i == length - 1));
        end
        if (!end_on_byte || length == 0)
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        int length;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty message, single extreme bytes carried together with the end.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        // "abc" with an ignored request in the middle.
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // "ab" closed by an end without a byte; its data must be ignored.
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);

        // Lengths around the padding boundary, sent back to back.
        gaps_on <= 1'b0;
        send_message(55, 1'b1, 0);
        send_message(56, 1'b0, 0);
        gaps_on <= 1'b1;
        // A full block whose last byte also ends the message.
        send_message(64, 1'b1, 0);

        while (requests_sent < ITEM_TARGET || messages_sent < MIN_MESSAGES) begin
            length = int'($urandom_range(0, 6));
            send_message(length, 1'($urandom_range(1)), 8);
        end
        s_tvalid <= 1'b0;

        while (digest_board.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Hashed %0d messages from %0d requests; %0d digest words checked.",
                 messages_sent, requests_sent, digest_board.words_checked);
        $display("Included empty and padding-boundary lengths, idle requests and a long output stall.");
        if (digest_board.mismatches == 0 && digest_board.pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
